[design/tej_pkg.sv]
// Shared types, constants and character helpers for the termcap line joiner.
package tej_pkg;

    localparam int WS_DEPTH = 16;
    // run buffer capacity, capped so one byte never gives more than 20 words
    localparam int WS_CAP   = (WS_DEPTH < 18) ? WS_DEPTH : 18;
    localparam int IDX_W    = (WS_CAP > 1) ? $clog2(WS_CAP) : 1;
    localparam int CNT_W    = $clog2(WS_CAP + 1);

    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_TAB  = 8'd9;
    localparam logic [7:0] CH_HASH = 8'd35;
    localparam logic [7:0] CH_BSL  = 8'd92;

    typedef enum logic [1:0] {
        SEL_NL = 2'd0,
        SEL_BS = 2'd1,
        SEL_WS = 2'd2,
        SEL_CH = 2'd3
    } out_sel_t;

    typedef struct packed {
        logic     accept;   // latch the input word
        logic     start;    // rewind the run read pointer
        logic     load;     // load one result word
        out_sel_t sel;
        logic     last;
        logic     commit;   // apply the line state update
    } cmd_t;

    typedef struct packed {
        logic nl;       // entry-closing newline goes out
        logic bs;       // held backslash goes out
        logic ws;       // buffered run goes out
        logic chr;      // the byte itself goes out
        logic ws_last;  // read pointer sits on the last buffered byte
        logic out_free; // output register can take a word
    } stat_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

endpackage

[design/tej_ctrl.sv]
// Sequencer: accepts a byte, then steps through the result words it causes.
module tej_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  tej_pkg::stat_t stat,
    output tej_pkg::cmd_t  cmd
);
    import tej_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_NL   = 6'b000100,
        ST_BS   = 6'b001000,
        ST_WS   = 6'b010000,
        ST_CH   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = SEL_NL;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.start = 1'b1;
                if (stat.nl)
                begin
                    if (stat.out_free)
                    begin
                        cmd.load   = 1'b1;
                        cmd.sel    = SEL_NL;
                        cmd.last   = 1'b1;
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_NL;
                    end
                end
                else if (stat.bs)
                begin
                    state_next = ST_BS;
                end
                else if (stat.ws)
                begin
                    state_next = ST_WS;
                end
                else if (stat.chr)
                begin
                    if (stat.out_free)
                    begin
                        cmd.load   = 1'b1;
                        cmd.sel    = SEL_CH;
                        cmd.last   = 1'b1;
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CH;
                    end
                end
                else
                begin
                    // byte only updates line state
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_NL:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = SEL_NL;
                    cmd.last   = 1'b1;
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_BS:
            begin
                if (stat.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.sel  = SEL_BS;
                    cmd.last = !stat.ws && !stat.chr;
                    if (stat.ws)
                    begin
                        state_next = ST_WS;
                    end
                    else if (stat.chr)
                    begin
                        state_next = ST_CH;
                    end
                    else
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WS:
            begin
                if (stat.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.sel  = SEL_WS;
                    cmd.last = stat.ws_last && !stat.chr;
                    if (stat.ws_last)
                    begin
                        if (stat.chr)
                        begin
                            state_next = ST_CH;
                        end
                        else
                        begin
                            cmd.commit = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_CH:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = SEL_CH;
                    cmd.last   = 1'b1;
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/tej_dp.sv]
// Datapath: line state, whitespace run buffer and the output word register.
module tej_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     s_tdata,
    input  logic           s_tuser,
    input  tej_pkg::cmd_t  cmd,
    output tej_pkg::stat_t stat,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast
);
    import tej_pkg::*;

    typedef enum logic [1:0] {
        PH_LEAD    = 2'd0,
        PH_KEEP    = 2'd1,
        PH_SKIP    = 2'd2,
        PH_COMMENT = 2'd3
    } phase_t;

    logic [7:0]       ch_reg;
    logic             end_reg;
    phase_t           phase_reg, phase_next;
    logic             tab_reg, tab_next;
    logic             held_reg, held_next;
    logic [CNT_W-1:0] ws_count_reg, ws_count_next;
    logic             has_data_reg, has_data_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [7:0]       ws_buf [WS_CAP];
    logic             buf_wr;

    logic             m_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_done_reg;
    logic             out_cut_reg;
    logic             out_last_reg;

    logic             c_ws;
    logic             c_nl;
    logic             cont;
    logic             body;
    logic             cut;

    always_comb
    begin
        c_ws = is_ws(ch_reg);
        c_nl = (ch_reg == CH_NL);
        cont = ((phase_reg == PH_KEEP) || (phase_reg == PH_SKIP)) && held_reg;
        body = !end_reg && !c_nl && !c_ws &&
               (((phase_reg == PH_LEAD) && (ch_reg != CH_HASH) &&
                 (is_letter(ch_reg) || tab_reg)) || (phase_reg == PH_KEEP));

        stat.nl       = end_reg ? has_data_reg : (c_nl && has_data_reg && !cont);
        stat.bs       = body && held_reg;
        stat.ws       = body && (ws_count_reg != '0);
        stat.chr      = body && (ch_reg != CH_BSL);
        stat.ws_last  = (CNT_W'(rd_idx_reg) == (ws_count_reg - CNT_W'(1)));
        stat.out_free = !m_valid_reg || m_tready;
        cut           = stat.ws && ovf_reg;
    end

    // line state update, applied when the last word of the byte is loaded, or at once if it gives none
    always_comb
    begin
        phase_next    = phase_reg;
        tab_next      = tab_reg;
        held_next     = held_reg;
        ws_count_next = ws_count_reg;
        has_data_next = has_data_reg;
        ovf_next      = ovf_reg;
        buf_wr        = 1'b0;
        if (end_reg || c_nl)
        begin
            if (end_reg || stat.nl)
            begin
                has_data_next = 1'b0;
            end
            phase_next    = PH_LEAD;
            tab_next      = 1'b0;
            held_next     = 1'b0;
            ws_count_next = '0;
            ovf_next      = 1'b0;
        end
        else if (body)
        begin
            phase_next    = PH_KEEP;
            held_next     = (ch_reg == CH_BSL);
            ws_count_next = '0;
            ovf_next      = 1'b0;
            if (stat.bs || stat.ws || stat.chr)
            begin
                has_data_next = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (c_ws)
                    begin
                        if (ch_reg == CH_TAB)
                        begin
                            tab_next = 1'b1;
                        end
                    end
                    else if (ch_reg == CH_HASH)
                    begin
                        phase_next = PH_COMMENT;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                        held_next  = (ch_reg == CH_BSL);
                    end
                end
                PH_KEEP:
                begin
                    // only whitespace reaches here
                    if (ws_count_reg < CNT_W'(WS_CAP))
                    begin
                        buf_wr        = 1'b1;
                        ws_count_next = ws_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    if (!c_ws)
                    begin
                        held_next = (ch_reg == CH_BSL);
                    end
                end
                PH_COMMENT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD;
            tab_reg      <= 1'b0;
            held_reg     <= 1'b0;
            ws_count_reg <= '0;
            has_data_reg <= 1'b0;
            ovf_reg      <= 1'b0;
            rd_idx_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                phase_reg    <= phase_next;
                tab_reg      <= tab_next;
                held_reg     <= held_next;
                ws_count_reg <= ws_count_next;
                has_data_reg <= has_data_next;
                ovf_reg      <= ovf_next;
            end
            if (cmd.start)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.load && (cmd.sel == SEL_WS))
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
            if (cmd.load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ch_reg  <= s_tdata;
            end_reg <= s_tuser;
        end
        if (cmd.commit && buf_wr)
        begin
            ws_buf[ws_count_reg[IDX_W-1:0]] <= ch_reg;
        end
        if (cmd.load)
        begin
            out_done_reg <= (cmd.sel == SEL_NL);
            out_cut_reg  <= cut;
            out_last_reg <= cmd.last;
            unique case (cmd.sel)
                SEL_NL: out_char_reg <= CH_NL;
                SEL_BS: out_char_reg <= CH_BSL;
                SEL_WS: out_char_reg <= ws_buf[rd_idx_reg];
                SEL_CH: out_char_reg <= ch_reg;
                default: out_char_reg <= ch_reg;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = {out_cut_reg, out_done_reg};
    assign m_tlast  = out_last_reg;

endmodule

[design/termcap_entry_line_joiner.sv]
// Top level of the termcap entry line joiner.
// Takes text one byte per word (tuser high marks end of input) and emits the
// joined entry bytes, one per word; tlast marks the final word caused by an
// input byte, and a byte that causes no word produces none. With the output
// free, a byte that gives no word, or only a closing newline or the byte
// itself, is accepted in the idle state and decided in the exec state, which
// also loads the output register. A byte that flushes a held backslash or
// buffered trailing whitespace leaves the exec state without a word and then
// sends its words one per cycle, while the output is free, through the single
// output register. At most 16 buffered whitespace bytes plus the backslash
// and the byte itself go out, so a byte gives at most 18 words. Output
// back-pressure can stall any of these steps. The whitespace run buffer
// holds 16 bytes; longer runs are cut and flagged in tuser.
module termcap_entry_line_joiner (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tuser,   // [0] is_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic [1:0] m_tuser,   // [0] entry_done, [1] ws_overflow
    output logic       m_tlast
);
    import tej_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tej_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tej_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[verif/termcap_entry_line_joiner_test.sv]
// Self-checking test of the termcap line joiner: directed table, random lines, stall phases.
module termcap_entry_line_joiner_test;
    import tej_pkg::*;

    localparam logic [7:0] CH_SP = 8'd32;
    localparam logic [7:0] CH_VT = 8'd11;
    localparam logic [7:0] CH_FF = 8'd12;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 60;

    typedef enum logic [1:0] {
        LP_LEAD    = 2'd0,
        LP_BODY    = 2'd1,
        LP_SKIP    = 2'd2,
        LP_COMMENT = 2'd3
    } line_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       done;
        logic       cut;
        logic       last;
    } joined_word_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         typed;
        int         n;
        logic [7:0] xch;
        logic       xdone;
    } plan_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tuser = 1'b0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire  [1:0] m_tuser;
    wire        m_tlast;

    termcap_entry_line_joiner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // predictor state
    line_phase_t  lp;
    logic         lead_tab;
    logic         bsl_held;
    logic [7:0]   run_buf [WS_CAP];
    int           run_len;
    logic         run_cut;
    logic         entry_open;

    joined_word_t step_words[$];
    joined_word_t joined_q[$];

    int errors = 0;
    int words_seen = 0;
    int items_sent = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    plan_row_t plan [25] = '{
        '{8'hFF,   1'b1, 1'b1, 0, 8'h00, 1'b0},  // end marker right after reset
        '{"A",     1'b0, 1'b1, 1, "A",   1'b0},
        '{CH_SP,   1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{CH_BSL,  1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{"z",     1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{CH_BSL,  1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{CH_NL,   1'b0, 1'b1, 0, 8'h00, 1'b0},  // continued line
        '{CH_TAB,  1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{"1",     1'b0, 1'b0, 0, 8'h00, 1'b0},  // kept through leading tab
        '{8'hFF,   1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{CH_CR,   1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{CH_VT,   1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{CH_BSL,  1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{CH_NL,   1'b0, 1'b1, 0, 8'h00, 1'b0},
        '{CH_NL,   1'b0, 1'b1, 1, CH_NL, 1'b1},  // empty line closes the entry
        '{CH_HASH, 1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{CH_NL,   1'b0, 1'b1, 0, 8'h00, 1'b0},
        '{8'h80,   1'b0, 1'b0, 0, 8'h00, 1'b0},  // non-ASCII lead: ignored body
        '{CH_BSL,  1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{CH_NL,   1'b0, 1'b1, 0, 8'h00, 1'b0},
        '{CH_FF,   1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{"a",     1'b0, 1'b1, 1, "a",   1'b0},
        '{CH_SP,   1'b0, 1'b0, 0, 8'h00, 1'b0},
        '{8'h00,   1'b1, 1'b1, 1, CH_NL, 1'b1},  // end drops trailing space, closes
        '{"Z",     1'b0, 1'b1, 1, "Z",   1'b0}
    };

    function automatic void flag(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    function automatic logic blank_byte(input logic [7:0] c);
        return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic void put_word(input logic [7:0] c, input logic done);
        joined_word_t w;
        w.ch = c;
        w.done = done;
        w.cut = 1'b0;
        w.last = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void reset_line();
        lp = LP_LEAD;
        lead_tab = 1'b0;
        bsl_held = 1'b0;
        run_len = 0;
        run_cut = 1'b0;
    endfunction

    // non-blank byte of a kept body: flush held backslash, then the run
    function automatic logic take_body(input logic [7:0] c);
        logic cut;
        cut = 1'b0;
        if (bsl_held) begin
            put_word(CH_BSL, 1'b0);
            entry_open = 1'b1;
            bsl_held = 1'b0;
        end
        if (run_len > 0) begin
            for (int i = 0; i < run_len; i++)
                put_word(run_buf[i], 1'b0);
            entry_open = 1'b1;
            cut = run_cut;
        end
        run_len = 0;
        run_cut = 1'b0;
        if (c == CH_BSL)
            bsl_held = 1'b1;
        else
        begin
            put_word(c, 1'b0);
            entry_open = 1'b1;
        end
        return cut;
    endfunction

    function automatic void predict_joined(input logic [7:0] c, input logic fin);
        logic cut;
        logic cont;
        cut = 1'b0;
        step_words.delete();
        if (fin) begin
            if (entry_open)
                put_word(CH_NL, 1'b1);
            reset_line();
            entry_open = 1'b0;
        end
        else if (c == CH_NL) begin
            cont = (lp == LP_BODY || lp == LP_SKIP) && bsl_held;
            if (entry_open && !cont) begin
                put_word(CH_NL, 1'b1);
                entry_open = 1'b0;
            end
            reset_line();
        end
        else
        begin
            case (lp)
                LP_LEAD:
                begin
                    if (blank_byte(c)) begin
                        if (c == CH_TAB)
                            lead_tab = 1'b1;
                    end
                    else if (c == CH_HASH)
                        lp = LP_COMMENT;
                    else if (alpha(c) || lead_tab) begin
                        lp = LP_BODY;
                        cut = take_body(c);
                    end
                    else
                    begin
                        lp = LP_SKIP;
                        bsl_held = (c == CH_BSL);
                    end
                end
                LP_BODY:
                begin
                    if (blank_byte(c)) begin
                        if (run_len < WS_CAP) begin
                            run_buf[run_len] = c;
                            run_len++;
                        end
                        else
                            run_cut = 1'b1;
                    end
                    else
                        cut = take_body(c);
                end
                LP_SKIP:
                begin
                    if (!blank_byte(c))
                        bsl_held = (c == CH_BSL);
                end
                default: ;
            endcase
        end
        foreach (step_words[k]) begin
            step_words[k].cut = cut;
            step_words[k].last = (k == step_words.size() - 1);
        end
    endfunction

    // offer one word, wait for the handshake, then queue its predicted output
    task automatic send(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        predict_joined(c, fin);
        foreach (step_words[k])
            joined_q.push_back(step_words[k]);
    endtask

    function automatic logic [7:0] rand_ws();
        case ($urandom_range(0, 4))
            0: return CH_TAB;
            1: return CH_VT;
            2: return CH_FF;
            3: return CH_CR;
            default: return CH_SP;
        endcase
    endfunction

    // non-blank, non-newline byte; half of them from the whole byte range
    function automatic logic [7:0] rand_body();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        if ($urandom_range(0, 1)) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_NL || blank_byte(c))
                c = c ^ 8'h80;
        end
        return c;
    endfunction

    task automatic send_run(input int len);
        repeat (len)
            send(rand_ws(), 1'b0);
    endtask

    task automatic random_line();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 6)
            send(8'($urandom_range(0, 255)), 1'b0);
        else if (r < 9)
            send(8'($urandom_range(0, 255)), 1'b1);
        else
        begin
            send_run($urandom_range(0, 3));
            r = $urandom_range(0, 9);
            if (r < 6) begin
                n = $urandom_range(0, 51);
                send((n < 26) ? 8'("A" + n) : 8'("a" + n - 26), 1'b0);
            end
            else if (r == 6)
                send(CH_HASH, 1'b0);
            else if (r == 7)
                send(CH_BSL, 1'b0);
            else
                send(rand_body(), 1'b0);
            repeat ($urandom_range(0, 5)) begin
                r = $urandom_range(0, 19);
                if (r < 10)
                    send(rand_body(), 1'b0);
                else if (r < 16)
                    send_run($urandom_range(1, 4));
                else if (r < 18)
                    send(CH_BSL, 1'b0);
                else if (r == 18)
                    send(8'($urandom_range(0, 255)) | 8'h01, 1'b0);
                else
                    send_run($urandom_range(WS_CAP - 2, WS_CAP + 6));  // may overflow
            end
            if ($urandom_range(0, 2) == 0)
                send_run($urandom_range(1, 3));
            if ($urandom_range(0, 3) == 0)
                send(CH_BSL, 1'b0);
            if ($urandom_range(0, 3) == 0)
                send_run($urandom_range(1, 2));
            if ($urandom_range(0, 11) == 0)
                send(8'($urandom_range(0, 255)), 1'b1);
            else
                send(CH_NL, 1'b0);
        end
    endtask

    // sender goes quiet until every predicted word has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (joined_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
        int stop_at;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            random_line();
        wait_drained();
    endtask

    // receiver; a long hold-off runs down here cycle by cycle
    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk) begin : check_words
        joined_word_t want;
        if (rst_n && m_tvalid && m_tready) begin
            words_seen++;
            if (joined_q.size() == 0)
                flag($sformatf("word %0d ch=%h arrived with nothing pending", words_seen,
                               m_tdata));
            else
            begin
                want = joined_q.pop_front();
                if (m_tdata !== want.ch || m_tuser[0] !== want.done ||
                    m_tuser[1] !== want.cut || m_tlast !== want.last)
                    flag($sformatf({"word %0d: expected ch=%h done=%b ovf=%b last=%b, ",
                                    "got ch=%h done=%b ovf=%b last=%b"},
                                   words_seen, want.ch, want.done, want.cut, want.last,
                                   m_tdata, m_tuser[0], m_tuser[1], m_tlast));
            end
        end
    end

    // watchdog on cycles where neither side moves a word
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int n;
        reset_line();
        entry_open = 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            send(plan[i].ch, plan[i].fin);
            if (plan[i].typed) begin
                n = step_words.size();
                if (n != plan[i].n ||
                    (n == 1 && (step_words[0].ch != plan[i].xch ||
                                step_words[0].done != plan[i].xdone)))
                    flag($sformatf("table row %0d: predicted %0d words", i, n));
                repeat (n)
                    void'(joined_q.pop_back());
                if (plan[i].n == 1)
                    joined_q.push_back('{plan[i].xch, plan[i].xdone, 1'b0, 1'b1});
            end
        end
        wait_drained();

        // block fills while the receiver holds off
        hold_left <= HOLD_CYCLES;
        run_phase(0, 0, 90);
        run_phase(84, 0, 90);
        run_phase(0, 84, 90);
        run_phase(9, 9, 90);

        rx_stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0 && joined_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
